/* hdl/hsv_pkg.sv */
// Shared types and constants of the harmonic sine synthesizer with vibrato.
// Holds the microword layout, datapath status, register file and sine polynomial constants.
// No dependencies; every other file of the block imports this package.
package hsv_pkg;

  // Fixed widths of the ports.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int STEP_W     = 31;
  localparam int AMP_W      = 16;
  localparam int SAMPLE_W   = 19;
  localparam int UPC_W      = 6;

  // Quarter-wave sine polynomial, odd terms, Q30, evaluated by Horner steps.
  localparam logic [30:0] POLY_C0 = 31'd1686629713;
  localparam logic [30:0] POLY_C1 = 31'd693598669;
  localparam logic [30:0] POLY_C2 = 31'd85569306;
  localparam logic [30:0] POLY_C3 = 31'd5026995;
  localparam logic [30:0] POLY_C4 = 31'd172272;

  // Sine full scale.
  localparam logic [30:0] SINE_FULL = 31'd32767;
  localparam logic [14:0] SINE_MAX  = 15'd32767;

  // Register file indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMP_LOW,
    REG_AMP_HIGH,
    REG_FREQ_STEP,
    REG_VIB_RATE,
    REG_VIB_DEPTH
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] amp_low;
    logic [CFG_DATA_W-1:0] amp_high;
    logic [STEP_W-1:0]     freq_step;
    logic [STEP_W-1:0]     vib_rate;
    logic [STEP_W-1:0]     vib_depth;
  } cfg_regs_t;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    MA_Z,
    MA_Z2,
    MA_P,
    MA_AMP,
    MA_DEPTH
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_Z,
    MB_C4,
    MB_P,
    MB_FULL,
    MB_MAG
  } mul_b_t;

  // Datapath write-back operations.
  typedef enum logic [3:0] {
    WB_NONE,
    WB_START,
    WB_LOADZ,
    WB_Z2,
    WB_HORNER,
    WB_S,
    WB_V,
    WB_ACC,
    WB_OUT,
    WB_DEV,
    WB_FIXED,
    WB_ADV
  } wb_op_t;

  // Phase that feeds the sine routine.
  typedef enum logic {
    SRC_HARM,
    SRC_VIB
  } ph_src_t;

  // Sequencer branch kinds.
  typedef enum logic [1:0] {
    J_NEXT,
    J_MORE,
    J_VIB_OFF,
    J_GOTO
  } jmp_t;

  // Handshake a step waits on.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_INPUT,
    STALL_OUTPUT
  } stall_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    mul_a_t     ma;
    mul_b_t     mb;
    wb_op_t     wb;
    logic [1:0] csel;
    ph_src_t    src;
    jmp_t       jmp;
    upc_t       tgt;
    stall_t     stall;
  } uword_t;

  typedef struct packed {
    logic harm_last;
    logic vib_off;
    logic out_busy;
  } dp_status_t;

endpackage

/* hdl/hsv_cfg.sv */
// Configuration register file of the harmonic sine synthesizer.
// Decodes the write channel and masks values to register width; uses hsv_pkg.
module hsv_cfg
  import hsv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;

  // The register file never back-pressures.
  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.amp_low   <= 64'd6554;
      regs_r.amp_high  <= '0;
      regs_r.freq_step <= 31'd42852281;
      regs_r.vib_rate  <= '0;
      regs_r.vib_depth <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AMP_LOW:   regs_r.amp_low   <= cfg_data;
        REG_AMP_HIGH:  regs_r.amp_high  <= cfg_data;
        REG_FREQ_STEP: regs_r.freq_step <= cfg_data[STEP_W-1:0];
        REG_VIB_RATE:  regs_r.vib_rate  <= cfg_data[STEP_W-1:0];
        REG_VIB_DEPTH: regs_r.vib_depth <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/hsv_seq.sv */
// Microcode sequencer of the harmonic sine synthesizer.
// Holds the program counter, the control-store table and the microword register; uses hsv_pkg.
module hsv_seq
  import hsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output uword_t     ctl,
  output logic       go
);

  // Program labels.
  localparam upc_t PC_IDLE   = 6'd0;
  localparam upc_t PC_HARM   = 6'd1;
  localparam upc_t PC_OUT    = 6'd18;
  localparam upc_t PC_VIB    = 6'd19;
  localparam upc_t PC_FIXED  = 6'd36;
  localparam upc_t PC_ADV    = 6'd37;
  localparam upc_t SINE_LAST = 6'd14;
  localparam upc_t SINE_AMP  = 6'd15;
  localparam upc_t SINE_WB   = 6'd16;

  localparam uword_t UWORD_NOP = '{ma: MA_Z, mb: MB_Z, wb: WB_NONE, csel: 2'd0,
                                   src: SRC_HARM, jmp: J_NEXT, tgt: PC_IDLE,
                                   stall: STALL_NONE};

  // Sine routine: fold into a quadrant, Horner polynomial, scale and round.
  function automatic uword_t sine_word(upc_t idx, ph_src_t src);
    uword_t w;
    w = UWORD_NOP;
    unique case (idx)
      6'd0:  begin w.wb = WB_LOADZ; w.src = src; end
      6'd1:  begin w.ma = MA_Z;  w.mb = MB_Z;  end
      6'd2:  w.wb = WB_Z2;
      6'd3:  begin w.ma = MA_Z2; w.mb = MB_C4; end
      6'd4:  begin w.wb = WB_HORNER; w.csel = 2'd3; end
      6'd5:  begin w.ma = MA_Z2; w.mb = MB_P;  end
      6'd6:  begin w.wb = WB_HORNER; w.csel = 2'd2; end
      6'd7:  begin w.ma = MA_Z2; w.mb = MB_P;  end
      6'd8:  begin w.wb = WB_HORNER; w.csel = 2'd1; end
      6'd9:  begin w.ma = MA_Z2; w.mb = MB_P;  end
      6'd10: begin w.wb = WB_HORNER; w.csel = 2'd0; end
      6'd11: begin w.ma = MA_Z;  w.mb = MB_P;  end
      6'd12: w.wb = WB_S;
      6'd13: begin w.ma = MA_P;  w.mb = MB_FULL; end
      6'd14: w.wb = WB_V;
      default: w = UWORD_NOP;
    endcase
    return w;
  endfunction

  // Control store.
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = UWORD_NOP;
    if (pc >= PC_HARM && pc <= PC_HARM + SINE_LAST) begin
      w = sine_word(pc - PC_HARM, SRC_HARM);
    end else if (pc >= PC_VIB && pc <= PC_VIB + SINE_LAST) begin
      w = sine_word(pc - PC_VIB, SRC_VIB);
    end else begin
      unique case (pc)
        PC_IDLE: begin
          w.wb    = WB_START;
          w.stall = STALL_INPUT;
        end
        PC_HARM + SINE_AMP: begin
          w.ma = MA_AMP;
          w.mb = MB_MAG;
        end
        PC_HARM + SINE_WB: begin
          w.wb  = WB_ACC;
          w.jmp = J_MORE;
          w.tgt = PC_HARM;
        end
        PC_OUT: begin
          w.wb    = WB_OUT;
          w.stall = STALL_OUTPUT;
          w.jmp   = J_VIB_OFF;
          w.tgt   = PC_FIXED;
        end
        PC_VIB + SINE_AMP: begin
          w.ma = MA_DEPTH;
          w.mb = MB_MAG;
        end
        PC_VIB + SINE_WB: begin
          w.wb  = WB_DEV;
          w.jmp = J_GOTO;
          w.tgt = PC_ADV;
        end
        PC_FIXED: w.wb = WB_FIXED;
        PC_ADV: begin
          w.wb  = WB_ADV;
          w.jmp = J_GOTO;
          w.tgt = PC_IDLE;
        end
        default: begin
          w.jmp = J_GOTO;
          w.tgt = PC_IDLE;
        end
      endcase
    end
    return w;
  endfunction

  upc_t   pc_r;
  upc_t   pc_nxt;
  uword_t uw_r;

  assign ctl      = uw_r;
  assign in_ready = (uw_r.stall == STALL_INPUT);

  // A step waits only for a word to arrive or for room in the output register.
  always_comb begin
    go = 1'b1;
    if (uw_r.stall == STALL_INPUT && !in_valid) begin
      go = 1'b0;
    end else if (uw_r.stall == STALL_OUTPUT && status.out_busy) begin
      go = 1'b0;
    end
  end

  // Next program counter from the branch field.
  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      unique case (uw_r.jmp)
        J_NEXT:    pc_nxt = pc_r + 1'b1;
        J_MORE:    pc_nxt = status.harm_last ? pc_r + 1'b1 : uw_r.tgt;
        J_VIB_OFF: pc_nxt = status.vib_off ? uw_r.tgt : pc_r + 1'b1;
        J_GOTO:    pc_nxt = uw_r.tgt;
        default:   pc_nxt = PC_IDLE;
      endcase
    end
  end

  // Program counter and microword register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
      uw_r <= ucode(PC_IDLE);
    end else begin
      pc_r <= pc_nxt;
      uw_r <= ucode(pc_nxt);
    end
  end

endmodule

/* hdl/hsv_dp.sv */
// Datapath of the harmonic sine synthesizer: one shared multiplier, phase adders,
// sine polynomial registers, sample accumulator and output register; uses hsv_pkg.
module hsv_dp
  import hsv_pkg::*;
#(
  parameter int HARMONICS      = 8,
  parameter int SINE_ADDR_BITS = 10,
  parameter int PHASE_BITS     = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  uword_t                     ctl,
  input  logic                       go,
  input  logic                       in_restart,
  input  cfg_regs_t                  cfg,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output dp_status_t                 status
);

  localparam int HW   = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int OFFW = SINE_ADDR_BITS - 1;
  localparam int ZPAD = 32 - SINE_ADDR_BITS;
  localparam logic [OFFW-1:0] QUARTER = OFFW'(1) << (SINE_ADDR_BITS - 2);

  function automatic logic [30:0] poly_coef(logic [1:0] csel);
    logic [30:0] c;
    unique case (csel)
      2'd0:    c = POLY_C0;
      2'd1:    c = POLY_C1;
      2'd2:    c = POLY_C2;
      default: c = POLY_C3;
    endcase
    return c;
  endfunction

  logic [PHASE_BITS-1:0]     harm_r;
  logic [PHASE_BITS-1:0]     vib_r;
  logic [PHASE_BITS-1:0]     ph_r;
  logic [PHASE_BITS-1:0]     step_r;
  logic [30:0]               z_r;
  logic [30:0]               z2_r;
  logic [30:0]               p_r;
  logic [1:0]                quad_r;
  logic [14:0]               mag_r;
  logic                      neg_r;
  logic [61:0]               prod_r;
  logic signed [35:0]        acc_r;
  logic [HW-1:0]             k_r;
  logic                      out_valid_r;
  logic [SAMPLE_W-1:0]       out_sample_r;

  logic [PHASE_BITS-1:0]     phase_sel;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [OFFW-1:0]           off_raw;
  logic [OFFW-1:0]           off;
  logic [127:0]              amp_all;
  logic [AMP_W-1:0]          amps [HARMONICS];
  logic [30:0]               mul_a;
  logic [30:0]               mul_b;
  logic [46:0]               round_v;
  logic [16:0]               v_trunc;
  logic [14:0]               mag_nxt;
  logic signed [35:0]        term;
  logic [PHASE_BITS-1:0]     fs_ext;
  logic [PHASE_BITS-1:0]     dev_ext;
  logic [PHASE_BITS-1:0]     rate_ext;

  // Sine address: fold the phase into a quarter-wave offset.
  always_comb begin
    phase_sel = (ctl.src == SRC_VIB) ? vib_r : ph_r;
    addr      = phase_sel[PHASE_BITS-1 -: SINE_ADDR_BITS];
    off_raw   = {1'b0, addr[SINE_ADDR_BITS-3:0]};
    off       = addr[SINE_ADDR_BITS-2] ? QUARTER - off_raw : off_raw;
  end

  // Amplitude of the current harmonic.
  always_comb begin
    amp_all = {cfg.amp_high, cfg.amp_low};
    for (int i = 0; i < HARMONICS; i++) begin
      amps[i] = amp_all[16*i +: 16];
    end
  end

  // Multiplier operand selection.
  always_comb begin
    unique case (ctl.ma)
      MA_Z:     mul_a = z_r;
      MA_Z2:    mul_a = z2_r;
      MA_P:     mul_a = p_r;
      MA_AMP:   mul_a = {15'b0, amps[k_r]};
      MA_DEPTH: mul_a = cfg.vib_depth;
      default:  mul_a = '0;
    endcase
    unique case (ctl.mb)
      MB_Z:    mul_b = z_r;
      MB_C4:   mul_b = POLY_C4;
      MB_P:    mul_b = p_r;
      MB_FULL: mul_b = SINE_FULL;
      MB_MAG:  mul_b = {16'b0, mag_r};
      default: mul_b = '0;
    endcase
  end

  // Rounding and capping of the scaled sine, and the other write-back operands.
  always_comb begin
    round_v  = {1'b0, prod_r[45:0]} + 47'd536870912;
    v_trunc  = round_v[46:30];
    mag_nxt  = (v_trunc > 17'd32767) ? SINE_MAX : v_trunc[14:0];
    term     = {5'b0, prod_r[30:0]};
    fs_ext   = PHASE_BITS'(cfg.freq_step);
    dev_ext  = PHASE_BITS'(prod_r[45:15]);
    rate_ext = PHASE_BITS'(cfg.vib_rate);
  end

  // Work registers; the product is registered on every cycle.
  always_ff @(posedge clk) begin
    prod_r <= 62'(mul_a) * 62'(mul_b);
    if (go) begin
      unique case (ctl.wb)
        WB_START: begin
          ph_r  <= in_restart ? '0 : harm_r;
          acc_r <= '0;
          k_r   <= '0;
        end
        WB_LOADZ: begin
          z_r    <= {off, {ZPAD{1'b0}}};
          quad_r <= addr[SINE_ADDR_BITS-1 -: 2];
        end
        WB_Z2:     z2_r <= prod_r[60:30];
        WB_HORNER: p_r  <= poly_coef(ctl.csel) - prod_r[60:30];
        WB_S:      p_r  <= prod_r[60:30];
        WB_V: begin
          mag_r <= mag_nxt;
          neg_r <= quad_r[1];
        end
        WB_ACC: begin
          acc_r <= neg_r ? acc_r - term : acc_r + term;
          ph_r  <= ph_r + harm_r;
          k_r   <= k_r + HW'(1);
        end
        WB_OUT:   out_sample_r <= acc_r[34:16];
        WB_DEV:   step_r <= neg_r ? fs_ext - dev_ext : fs_ext + dev_ext;
        WB_FIXED: step_r <= fs_ext;
        default: ;
      endcase
    end
  end

  // Phase state and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      harm_r      <= '0;
      vib_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go && ctl.wb == WB_START && in_restart) begin
        harm_r <= '0;
      end else if (go && ctl.wb == WB_ADV) begin
        harm_r <= harm_r + step_r;
      end
      if (go && ctl.wb == WB_DEV) begin
        vib_r <= vib_r + rate_ext;
      end
      if (go && ctl.wb == WB_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign status.harm_last = (k_r == HW'(HARMONICS - 1));
  assign status.vib_off   = (cfg.vib_rate == '0);
  assign status.out_busy  = out_valid_r && !out_ready;

endmodule

/* hdl/harmonic_sine_synth_vibrato_top.sv */
// Harmonic sine synthesizer with vibrato, top level; uses hsv_pkg, hsv_cfg, hsv_seq, hsv_dp.
// out_valid rises after the harmonic loop, when the output step registers the sum of all harmonics.
// A new word is taken only after the microprogram has finished the last one and its vibrato step;
// each sine takes fifteen steps on the one shared multiplier.
// The next word is accepted while a finished sample still waits in the output register.
// Reset (synchronous, active low) loads register defaults, clears both phases, idles the sequencer.
module harmonic_sine_synth_vibrato_top
  import hsv_pkg::*;
#(
  parameter int HARMONICS      = 8,
  parameter int SINE_ADDR_BITS = 10,
  parameter int PHASE_BITS     = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  cfg_regs_t  regs;
  uword_t     ctl;
  dp_status_t status;
  logic       go;

  // Register file.
  hsv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Microcode sequencer.
  hsv_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .ctl      (ctl),
    .go       (go)
  );

  // Datapath.
  hsv_dp #(
    .HARMONICS      (HARMONICS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .PHASE_BITS     (PHASE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .go         (go),
    .in_restart (in_restart),
    .cfg        (regs),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_sample (out_sample),
    .status     (status)
  );

endmodule

/* hdl/hsv_checker.sv */
// Port-level checker for the harmonic sine synthesizer and the bind that attaches it.
// Depends on hsv_pkg and on the port list of harmonic_sine_synth_vibrato_top.
module hsv_checker
  import hsv_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words accepted whose sample has not yet been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // One word at a time is worked on.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("in_ready stayed high after an accepted word");

  // A stalled sample holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled sample changed or dropped");

  // No sample without an accepted word.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("sample presented without a pending word");

  // At most one word waits behind a finished sample.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> pend_r < 2'd2)
    else $error("input taken with two words pending");

endmodule

bind harmonic_sine_synth_vibrato_top hsv_checker u_hsv_checker (.*);
